### sv/cdq_pkg.sv
// ---------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque
// Command codes, field widths and the request and response beat layouts.
// ---------------------------------------------------------------------------
package cdq_pkg;

  // Fixed field widths
  localparam int CMD_W = 3;
  localparam int VAL_W = 32;
  localparam int CAP_W = 11;

  // Configuration port widths
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Defaults for the top-level parameters
  localparam int MAX_DEPTH_DEFAULT  = 1024;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Capacity loaded at reset, before clamping to the ring size
  localparam int CAP_RESET_RAW = 1024;

  // Register byte addresses
  localparam logic [APB_AW-1:0] REG_CAPACITY = 3'd0;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;

  // Request beat
  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
  } req_t;

  // Response beat
  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] rear_value;
    logic                    empty_flag;
    logic                    full_flag;
    logic [CAP_W-1:0]        occupancy;
  } rsp_t;

endpackage

### sv/circular_deque.sv
// ---------------------------------------------------------------------------
// circular_deque: double-ended queue in a ring memory
// Takes commands that push or pop at either end, or peek, and returns one
// response beat per command with the state of the deque after it.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid, req_stall, req) carries a command and a
//   value. Response channel (rsp_valid, rsp_stall, rsp) carries one beat
//   per request: ok, front and rear entries (-1 when empty), the empty and
//   full flags and the occupancy.
//   The APB port holds one register, capacity, at byte address 0. Writing
//   it empties the deque; only the low 11 bits of pwdata are used, zero
//   is taken as one and values above MAX_DEPTH are clamped. The user must
//   write it only while no request is in flight; the block does not
//   enforce this. Throughput: one request per cycle while the receiver
//   does not stall; the ring memory has one write port and two registered
//   read ports, and a same-cycle write is forwarded to the reads.
//   Reset empties the deque and sets the capacity to 1024 (or MAX_DEPTH if
//   smaller). Ring contents are not cleared; only written entries are read.
//   When the receiver stalls, the response register holds, then the read
//   stage fills, and req_stall rises until the response is taken.
// ---------------------------------------------------------------------------
module circular_deque #(
  parameter int MAX_DEPTH  = cdq_pkg::MAX_DEPTH_DEFAULT,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cdq_pkg::APB_AW-1:0]  paddr,
  input  logic [cdq_pkg::APB_DW-1:0]  pwdata,
  output logic [cdq_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // Request channel
  input  logic                        req_valid,
  output logic                        req_stall,
  input  cdq_pkg::req_t               req,
  // Response channel
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output cdq_pkg::rsp_t               rsp
);
  import cdq_pkg::*;

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int PW = ((AW > CAP_W) ? AW : CAP_W) + 1;
  localparam int XW = DATA_WIDTH + VAL_W;
  localparam logic [CAP_W-1:0] CAP_RESET =
    CAP_W'((MAX_DEPTH < CAP_RESET_RAW) ? MAX_DEPTH : CAP_RESET_RAW);

  // Ring memory and its registered read data
  logic [DATA_WIDTH-1:0] ring [MAX_DEPTH];
  logic [DATA_WIDTH-1:0] rd_front;
  logic [DATA_WIDTH-1:0] rd_rear;

  // Deque state
  logic [CAP_W-1:0] capacity;
  logic [AW-1:0]    head;
  logic [AW-1:0]    tail;
  logic [CAP_W-1:0] count;

  // Read stage
  logic                  s1_valid;
  logic                  s1_ok;
  logic [CAP_W-1:0]      s1_count;
  logic                  s1_full;
  logic                  s1_fwd_front;
  logic                  s1_fwd_rear;
  logic [DATA_WIDTH-1:0] s1_wdata;

  // Next-state logic
  logic [AW-1:0]         head_next;
  logic [AW-1:0]         tail_next;
  logic [CAP_W-1:0]      count_next;
  logic                  ok_next;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [XW-1:0]         value_ext;
  logic [PW-1:0]         cap_m1;
  logic                  is_full;
  logic                  is_empty;
  logic                  head_wrap;
  logic                  tail_wrap;
  logic [AW-1:0]         head_inc;
  logic [AW-1:0]         head_dec;
  logic [AW-1:0]         tail_inc;
  logic [AW-1:0]         tail_dec;

  // Handshakes
  logic accept;
  logic s1_move;
  logic cfg_wr;

  // Configuration write decode and clamped capacity
  logic [CAP_W-1:0] cap_raw;
  logic [CAP_W-1:0] cap_clamped;
  logic [PW-1:0]    cfg_cap_m1;

  // Response formatting
  logic [DATA_WIDTH-1:0] front_data;
  logic [DATA_WIDTH-1:0] rear_data;
  logic [XW-1:0]         front_ext;
  logic [XW-1:0]         rear_ext;
  rsp_t                  rsp_next;

  // APB port: always ready, one readable register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_CAPACITY[APB_AW-1]);
  assign prdata = (paddr[APB_AW-1] == REG_CAPACITY[APB_AW-1]) ?
                  APB_DW'(capacity) : '0;

  // Capacity clamp on the low 11 bits of pwdata: zero counts as one, too large saturates at the ring size
  always_comb begin
    cap_raw = pwdata[CAP_W-1:0];
    if (cap_raw == '0) begin
      cap_clamped = CAP_W'(1);
    end else if (PW'(cap_raw) > PW'(MAX_DEPTH)) begin
      cap_clamped = CAP_W'(MAX_DEPTH);
    end else begin
      cap_clamped = cap_raw;
    end
    cfg_cap_m1 = PW'(cap_clamped) - PW'(1);
  end

  // Handshake: the read stage advances when the response register frees up
  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_move;
  assign accept    = req_valid && !req_stall;

  // Pointer arithmetic modulo the capacity
  always_comb begin
    cap_m1    = PW'(capacity) - PW'(1);
    is_full   = (count >= capacity);
    is_empty  = (count == '0);
    head_wrap = (PW'(head) + PW'(1)) >= PW'(capacity);
    tail_wrap = (PW'(tail) + PW'(1)) >= PW'(capacity);
    head_inc  = head_wrap ? '0 : head + AW'(1);
    tail_inc  = tail_wrap ? '0 : tail + AW'(1);
    head_dec  = (head == '0) ? cap_m1[AW-1:0] : head - AW'(1);
    tail_dec  = (tail == '0) ? cap_m1[AW-1:0] : tail - AW'(1);
  end

  // Value to store, kept to the ring width
  assign value_ext = {{DATA_WIDTH{1'b0}}, req.value};
  assign wdata     = value_ext[DATA_WIDTH-1:0];

  // Command decode
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    ok_next    = 1'b1;
    wr_en      = 1'b0;
    wr_addr    = head_dec;
    unique case (req.cmd)
      CMD_PUSH_FRONT: begin
        if (is_full) begin
          ok_next = 1'b0;
        end else begin
          head_next  = head_dec;
          wr_addr    = head_dec;
          wr_en      = accept;
          count_next = count + CAP_W'(1);
        end
      end
      CMD_PUSH_REAR: begin
        if (is_full) begin
          ok_next = 1'b0;
        end else begin
          tail_next  = tail_inc;
          wr_addr    = tail_inc;
          wr_en      = accept;
          count_next = count + CAP_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (is_empty) begin
          ok_next = 1'b0;
        end else begin
          head_next  = head_inc;
          count_next = count - CAP_W'(1);
        end
      end
      CMD_POP_REAR: begin
        if (is_empty) begin
          ok_next = 1'b0;
        end else begin
          tail_next  = tail_dec;
          count_next = count - CAP_W'(1);
        end
      end
      default: begin
        // Peek and unused codes leave the deque unchanged.
      end
    endcase
  end

  // Ring memory: one write, two reads at the new end positions
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wdata;
    end
    if (accept) begin
      rd_front <= ring[head_next];
      rd_rear  <= ring[tail_next];
    end
  end

  // Deque state and capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      head     <= '0;
      tail     <= AW'(CAP_RESET - CAP_W'(1));
      count    <= '0;
    end else if (cfg_wr) begin
      capacity <= cap_clamped;
      head     <= '0;
      tail     <= cfg_cap_m1[AW-1:0];
      count    <= '0;
    end else if (accept) begin
      head     <= head_next;
      tail     <= tail_next;
      count    <= count_next;
    end
  end

  // Read stage: control and forwarding of a same-cycle write
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok        <= ok_next;
      s1_count     <= count_next;
      s1_full      <= (count_next == capacity);
      s1_fwd_front <= wr_en && (head_next == wr_addr);
      s1_fwd_rear  <= wr_en && (tail_next == wr_addr);
      s1_wdata     <= wdata;
    end
  end

  // Response formatting
  always_comb begin
    front_data = s1_fwd_front ? s1_wdata : rd_front;
    rear_data  = s1_fwd_rear  ? s1_wdata : rd_rear;
    front_ext  = {{VAL_W{1'b0}}, front_data};
    rear_ext   = {{VAL_W{1'b0}}, rear_data};
    rsp_next.ok         = s1_ok;
    rsp_next.empty_flag = (s1_count == '0);
    rsp_next.full_flag  = s1_full;
    rsp_next.occupancy  = s1_count;
    if (s1_count == '0) begin
      rsp_next.front_value = '1;
      rsp_next.rear_value  = '1;
    end else begin
      rsp_next.front_value = front_ext[VAL_W-1:0];
      rsp_next.rear_value  = rear_ext[VAL_W-1:0];
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp <= rsp_next;
    end
  end

endmodule

### sv/cdq_checker.sv
// ---------------------------------------------------------------------------
// cdq_checker: port-level checks for the circular deque
// Watches the response channel for consistent flags and stable stalls.
// ---------------------------------------------------------------------------
module cdq_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input cdq_pkg::rsp_t rsp
);
  import cdq_pkg::*;

  // The empty flag agrees with the occupancy.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.empty_flag == (rsp.occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

  // An empty deque shows -1 at both ends.
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.empty_flag) |->
      (rsp.front_value == -32'sd1) && (rsp.rear_value == -32'sd1))
    else $error("empty deque shows an entry");

  // Capacity is at least one, so a full deque is never empty.
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.full_flag) |-> !rsp.empty_flag)
    else $error("deque reported full and empty");

  // A stalled response beat holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response beat changed");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
